// File: rtl/ffha_pkg.sv
// ----------------------------------------------------------------------------
// First-fit heap allocator package
// Request modes, status codes, register indexes, result kinds and the
// command and status groups between the controller and the datapath.
// ----------------------------------------------------------------------------
package ffha_pkg;

    localparam logic [1:0] MODE_ALLOC = 2'd0;
    localparam logic [1:0] MODE_FREE  = 2'd1;
    localparam logic [1:0] MODE_FIND  = 2'd2;
    localparam logic [1:0] MODE_ADDR  = 2'd3;

    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_NO_GAP    = 2'd1;
    localparam logic [1:0] ST_FULL      = 2'd2;
    localparam logic [1:0] ST_NOT_FOUND = 2'd3;

    localparam int unsigned APB_AW        = 3;
    localparam logic        REG_HEAP_BASE = 1'b0;
    localparam logic        REG_HEAP_END  = 1'b1;

    localparam logic [2:0] RES_NO_GAP    = 3'd0;
    localparam logic [2:0] RES_FULL      = 3'd1;
    localparam logic [2:0] RES_NOT_FOUND = 3'd2;
    localparam logic [2:0] RES_ALLOC     = 3'd3;
    localparam logic [2:0] RES_FREE      = 3'd4;
    localparam logic [2:0] RES_FIND      = 3'd5;
    localparam logic [2:0] RES_ADDR      = 3'd6;

    typedef struct packed {
        logic       load;
        logic       walk_init;
        logic       walk_step;
        logic       wr_new;
        logic       wr_link;
        logic       unlink;
        logic       look_rd;
        logic       set_res;
        logic [2:0] res;
        logic       push;
    } t_cmd;

    typedef struct packed {
        logic [1:0] mode;
        logic       size_done;
        logic       walk_end;
        logic       hit;
        logic       tail_fit;
        logic       scan_done;
        logic       scan_full;
        logic       look_ok;
        logic       out_free;
    } t_stat;

endpackage

// File: rtl/ffha_req_if.sv
// ----------------------------------------------------------------------------
// Allocator request channel
// Valid/ready channel carrying one request per beat.
// ----------------------------------------------------------------------------
interface ffha_req_if;
    logic        valid;
    logic        ready;
    logic [1:0]  mode;
    logic [31:0] req_size;
    logic [31:0] req_address;
    logic [5:0]  req_block;

    modport source (output valid, output mode, output req_size, output req_address,
                    output req_block, input ready);
    modport sink   (input valid, input mode, input req_size, input req_address,
                    input req_block, output ready);
endinterface

// File: rtl/ffha_rsp_if.sv
// ----------------------------------------------------------------------------
// Allocator response channel
// Valid/ready channel carrying one result per beat.
// ----------------------------------------------------------------------------
interface ffha_rsp_if;
    logic        valid;
    logic        ready;
    logic [31:0] result_address;
    logic [5:0]  result_block;
    logic [1:0]  status;

    modport source (output valid, output result_address, output result_block,
                    output status, input ready);
    modport sink   (input valid, input result_address, input result_block,
                    input status, output ready);
endinterface

// File: rtl/ffha_apb.sv
// ----------------------------------------------------------------------------
// Allocator configuration registers
// APB-style write and read access to the heap base and heap end registers.
// ----------------------------------------------------------------------------
module ffha_apb (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [ffha_pkg::APB_AW-1:0]   paddr,
    input  logic [31:0]                   pwdata,
    output logic [31:0]                   prdata,
    output logic                          pready,
    output logic [31:0]                   o_heap_base,
    output logic [31:0]                   o_heap_end
);

    logic [31:0] r_heap_base;
    logic [31:0] r_heap_end;
    logic        s_sel_end;
    logic        s_wr;

    assign s_sel_end = (paddr[ffha_pkg::APB_AW-1] == ffha_pkg::REG_HEAP_END);
    assign s_wr      = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_heap_base <= '0;
            r_heap_end  <= '0;
        end else if (s_wr) begin
            if (s_sel_end) begin
                r_heap_end <= pwdata;
            end else begin
                r_heap_base <= pwdata;
            end
        end
    end

    assign prdata      = s_sel_end ? r_heap_end : r_heap_base;
    assign pready      = 1'b1;
    assign o_heap_base = r_heap_base;
    assign o_heap_end  = r_heap_end;

endmodule

// File: rtl/ffha_ctrl.sv
// ----------------------------------------------------------------------------
// Allocator controller
// Sequences size rounding, the list walk, the free-id wait, table updates
// and the result beat for each request.
// ----------------------------------------------------------------------------
module ffha_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    output logic            o_in_ready,
    input  ffha_pkg::t_stat i_stat,
    output ffha_pkg::t_cmd  o_cmd
);

    localparam logic [3:0] S_IDLE   = 4'd0;
    localparam logic [3:0] S_DISP   = 4'd1;
    localparam logic [3:0] S_SIZE   = 4'd2;
    localparam logic [3:0] S_WSTART = 4'd3;
    localparam logic [3:0] S_WALK   = 4'd4;
    localparam logic [3:0] S_SCANW  = 4'd5;
    localparam logic [3:0] S_WR1    = 4'd6;
    localparam logic [3:0] S_WR2    = 4'd7;
    localparam logic [3:0] S_UNLINK = 4'd8;
    localparam logic [3:0] S_LOOK   = 4'd9;
    localparam logic [3:0] S_LOOK2  = 4'd10;
    localparam logic [3:0] S_DONE   = 4'd11;

    logic [3:0] r_state;
    logic [3:0] n_state;
    logic       s_alloc;

    assign s_alloc = (i_stat.mode == ffha_pkg::MODE_ALLOC);

    always_comb begin
        o_cmd   = '0;
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_DISP;
                end
            end
            S_DISP: begin
                unique case (i_stat.mode)
                    ffha_pkg::MODE_ALLOC: n_state = S_SIZE;
                    ffha_pkg::MODE_FREE:  n_state = S_WSTART;
                    ffha_pkg::MODE_FIND:  n_state = S_WSTART;
                    ffha_pkg::MODE_ADDR:  n_state = S_LOOK;
                    default:              n_state = S_IDLE;
                endcase
            end
            S_SIZE: begin
                if (i_stat.size_done) begin
                    n_state = S_WSTART;
                end
            end
            S_WSTART: begin
                o_cmd.walk_init = 1'b1;
                n_state         = S_WALK;
            end
            S_WALK: begin
                priority if (i_stat.walk_end) begin
                    if (s_alloc && i_stat.tail_fit) begin
                        n_state = S_SCANW;
                    end else begin
                        o_cmd.set_res = 1'b1;
                        o_cmd.res     = s_alloc ? ffha_pkg::RES_NO_GAP
                                                : ffha_pkg::RES_NOT_FOUND;
                        n_state       = S_DONE;
                    end
                end else if (i_stat.hit) begin
                    if (s_alloc) begin
                        n_state = S_SCANW;
                    end else if (i_stat.mode == ffha_pkg::MODE_FREE) begin
                        n_state = S_UNLINK;
                    end else begin
                        o_cmd.set_res = 1'b1;
                        o_cmd.res     = ffha_pkg::RES_FIND;
                        n_state       = S_DONE;
                    end
                end else begin
                    o_cmd.walk_step = 1'b1;
                end
            end
            S_SCANW: begin
                if (i_stat.scan_done) begin
                    if (i_stat.scan_full) begin
                        o_cmd.set_res = 1'b1;
                        o_cmd.res     = ffha_pkg::RES_FULL;
                        n_state       = S_DONE;
                    end else begin
                        n_state = S_WR1;
                    end
                end
            end
            S_WR1: begin
                o_cmd.wr_new = 1'b1;
                n_state      = S_WR2;
            end
            S_WR2: begin
                o_cmd.wr_link = 1'b1;
                o_cmd.set_res = 1'b1;
                o_cmd.res     = ffha_pkg::RES_ALLOC;
                n_state       = S_DONE;
            end
            S_UNLINK: begin
                o_cmd.unlink  = 1'b1;
                o_cmd.set_res = 1'b1;
                o_cmd.res     = ffha_pkg::RES_FREE;
                n_state       = S_DONE;
            end
            S_LOOK: begin
                if (i_stat.look_ok) begin
                    o_cmd.look_rd = 1'b1;
                    n_state       = S_LOOK2;
                end else begin
                    o_cmd.set_res = 1'b1;
                    o_cmd.res     = ffha_pkg::RES_NOT_FOUND;
                    n_state       = S_DONE;
                end
            end
            S_LOOK2: begin
                o_cmd.set_res = 1'b1;
                o_cmd.res     = ffha_pkg::RES_ADDR;
                n_state       = S_DONE;
            end
            S_DONE: begin
                if (i_stat.out_free) begin
                    o_cmd.push = 1'b1;
                    n_state    = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_in_ready = (r_state == S_IDLE);

endmodule

// File: rtl/ffha_dp.sv
// ----------------------------------------------------------------------------
// Allocator datapath
// Block tables, list head, used bits, size rounding, walk registers,
// free-id scan and the result register.
// ----------------------------------------------------------------------------
module ffha_dp #(
    parameter int MAX_BLOCKS = 64,
    parameter int GRANULE    = 256
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  ffha_pkg::t_cmd  i_cmd,
    output ffha_pkg::t_stat o_stat,
    input  logic [1:0]      i_mode,
    input  logic [31:0]     i_req_size,
    input  logic [31:0]     i_req_address,
    input  logic [5:0]      i_req_block,
    input  logic [31:0]     i_heap_base,
    input  logic [31:0]     i_heap_end,
    input  logic            i_out_ready,
    output logic            o_out_valid,
    output logic [31:0]     o_result_address,
    output logic [5:0]      o_result_block,
    output logic [1:0]      o_status
);

    localparam int ID_W = $clog2(MAX_BLOCKS);
    localparam int CW   = $clog2(MAX_BLOCKS + 1);

    logic [31:0]           r_off_mem  [MAX_BLOCKS];
    logic [31:0]           r_len_mem  [MAX_BLOCKS];
    logic [ID_W-1:0]       r_link_mem [MAX_BLOCKS];
    logic [31:0]           r_rd_off;
    logic [31:0]           r_rd_len;
    logic [ID_W-1:0]       r_rd_link;
    logic [MAX_BLOCKS-1:0] r_used;
    logic [ID_W-1:0]       r_head;

    logic [1:0]      r_mode;
    logic [31:0]     r_key;
    logic [5:0]      r_blk;
    logic [32:0]     r_size;
    logic            s_size_done;
    logic [ID_W-1:0] r_cur;
    logic [ID_W-1:0] r_prev;
    logic [32:0]     r_begin;
    logic [CW-1:0]   r_scan;
    logic            r_scan_run;

    logic [31:0] r_res_addr;
    logic [5:0]  r_res_blk;
    logic [1:0]  r_res_st;
    logic        r_out_valid;
    logic [31:0] r_out_addr;
    logic [5:0]  r_out_blk;
    logic [1:0]  r_out_st;

    logic [ID_W-1:0] s_rd_addr;
    logic [ID_W-1:0] s_new_id;
    logic [ID_W-1:0] s_blk_id;
    logic            s_scan_full;
    logic [32:0]     s_end;
    logic [32:0]     s_hsize;
    logic            s_fit;
    logic            s_tail_fit;
    logic            s_link_we;
    logic [ID_W-1:0] s_link_wa;
    logic [ID_W-1:0] s_link_wd;
    logic            s_put_link;
    logic            s_out_free;

    assign s_new_id    = r_scan[ID_W-1:0];
    assign s_blk_id    = ID_W'(r_blk);
    assign s_scan_full = (r_scan == CW'(MAX_BLOCKS));

    // Request registers.
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_mode <= i_mode;
            r_key  <= i_req_address - i_heap_base;
            r_blk  <= i_req_block;
        end
    end

    // Size rounding up to the granule.
    if ((GRANULE & (GRANULE - 1)) == 0) begin : g_size_pow2
        always_ff @(posedge i_clk) begin
            if (i_cmd.load) begin
                r_size <= (33'(i_req_size) + 33'(GRANULE - 1)) & ~33'(GRANULE - 1);
            end
        end
        assign s_size_done = 1'b1;
    end else begin : g_size_rem
        localparam int RW = $clog2(GRANULE);
        logic [RW-1:0] r_rem;
        logic [5:0]    r_bit;
        logic          r_sdone;
        logic [31:0]   r_req_sz;
        logic [RW:0]   s_trial;

        assign s_trial = {r_rem, r_req_sz[5'(r_bit - 6'd1)]};

        always_ff @(posedge i_clk) begin
            if (i_cmd.load) begin
                r_req_sz <= i_req_size;
                r_rem    <= '0;
            end else if (r_bit != 6'd0) begin
                r_rem <= (s_trial >= (RW+1)'(GRANULE)) ? RW'(s_trial - (RW+1)'(GRANULE))
                                                       : RW'(s_trial);
            end else if (!r_sdone) begin
                r_size <= 33'(r_req_sz) + ((r_rem == '0) ? 33'd0
                                           : (33'(GRANULE) - 33'(r_rem)));
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_bit   <= '0;
                r_sdone <= 1'b0;
            end else if (i_cmd.load) begin
                r_bit   <= 6'd32;
                r_sdone <= 1'b0;
            end else if (r_bit != 6'd0) begin
                r_bit <= r_bit - 6'd1;
            end else begin
                r_sdone <= 1'b1;
            end
        end

        assign s_size_done = r_sdone;
    end

    // Free block id scan, one id per cycle.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_scan     <= CW'(1);
            r_scan_run <= 1'b0;
        end else if (i_cmd.load) begin
            r_scan     <= CW'(1);
            r_scan_run <= (i_mode == ffha_pkg::MODE_ALLOC);
        end else if (r_scan_run) begin
            if (s_scan_full || !r_used[s_new_id]) begin
                r_scan_run <= 1'b0;
            end else begin
                r_scan <= r_scan + CW'(1);
            end
        end
    end

    // List walk.
    assign s_end   = {1'b0, r_rd_off};
    assign s_hsize = (i_heap_end >= i_heap_base) ? {1'b0, i_heap_end - i_heap_base} : '0;
    assign s_fit      = (s_end >= r_begin) && ((s_end - r_begin) >= r_size);
    assign s_tail_fit = (s_hsize >= r_begin) && ((s_hsize - r_begin) >= r_size);

    always_ff @(posedge i_clk) begin
        if (i_cmd.walk_init) begin
            r_cur   <= r_head;
            r_prev  <= '0;
            r_begin <= '0;
        end else if (i_cmd.walk_step) begin
            r_cur   <= r_rd_link;
            r_prev  <= r_cur;
            r_begin <= {1'b0, r_rd_off} + {1'b0, r_rd_len};
        end
    end

    always_comb begin
        priority if (i_cmd.walk_init) begin
            s_rd_addr = r_head;
        end else if (i_cmd.walk_step) begin
            s_rd_addr = r_rd_link;
        end else if (i_cmd.look_rd) begin
            s_rd_addr = s_blk_id;
        end else begin
            s_rd_addr = r_cur;
        end
    end

    // Block tables.
    assign s_put_link = i_cmd.wr_link || i_cmd.unlink;
    assign s_link_we  = i_cmd.wr_new || (s_put_link && (r_prev != '0));
    assign s_link_wa  = i_cmd.wr_new ? s_new_id : r_prev;
    assign s_link_wd  = i_cmd.wr_new ? r_cur : (i_cmd.wr_link ? s_new_id : r_rd_link);

    always_ff @(posedge i_clk) begin
        if (i_cmd.wr_new) begin
            r_off_mem[s_new_id] <= r_begin[31:0];
            r_len_mem[s_new_id] <= r_size[31:0];
        end
        r_rd_off <= r_off_mem[s_rd_addr];
        r_rd_len <= r_len_mem[s_rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (s_link_we) begin
            r_link_mem[s_link_wa] <= s_link_wd;
        end
        r_rd_link <= r_link_mem[s_rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head <= '0;
            r_used <= '0;
        end else begin
            if (s_put_link && (r_prev == '0)) begin
                r_head <= i_cmd.wr_link ? s_new_id : r_rd_link;
            end
            if (i_cmd.wr_new) begin
                r_used[s_new_id] <= 1'b1;
            end else if (i_cmd.unlink) begin
                r_used[r_cur] <= 1'b0;
            end
        end
    end

    // Result and output registers.
    always_ff @(posedge i_clk) begin
        if (i_cmd.set_res) begin
            unique case (i_cmd.res)
                ffha_pkg::RES_NO_GAP: begin
                    r_res_addr <= '0;
                    r_res_blk  <= '0;
                    r_res_st   <= ffha_pkg::ST_NO_GAP;
                end
                ffha_pkg::RES_FULL: begin
                    r_res_addr <= '0;
                    r_res_blk  <= '0;
                    r_res_st   <= ffha_pkg::ST_FULL;
                end
                ffha_pkg::RES_ALLOC: begin
                    r_res_addr <= i_heap_base + r_begin[31:0];
                    r_res_blk  <= 6'(s_new_id);
                    r_res_st   <= ffha_pkg::ST_OK;
                end
                ffha_pkg::RES_FREE: begin
                    r_res_addr <= '0;
                    r_res_blk  <= 6'(r_cur);
                    r_res_st   <= ffha_pkg::ST_OK;
                end
                ffha_pkg::RES_FIND: begin
                    r_res_addr <= i_heap_base + r_rd_off;
                    r_res_blk  <= 6'(r_cur);
                    r_res_st   <= ffha_pkg::ST_OK;
                end
                ffha_pkg::RES_ADDR: begin
                    r_res_addr <= i_heap_base + r_rd_off;
                    r_res_blk  <= '0;
                    r_res_st   <= ffha_pkg::ST_OK;
                end
                default: begin
                    r_res_addr <= '0;
                    r_res_blk  <= '0;
                    r_res_st   <= ffha_pkg::ST_NOT_FOUND;
                end
            endcase
        end
    end

    assign s_out_free = !r_out_valid || i_out_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.push) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.push) begin
            r_out_addr <= r_res_addr;
            r_out_blk  <= r_res_blk;
            r_out_st   <= r_res_st;
        end
    end

    assign o_out_valid      = r_out_valid;
    assign o_result_address = r_out_addr;
    assign o_result_block   = r_out_blk;
    assign o_status         = r_out_st;

    always_comb begin
        o_stat           = '0;
        o_stat.mode      = r_mode;
        o_stat.size_done = s_size_done;
        o_stat.walk_end  = (r_cur == '0);
        o_stat.hit       = (r_mode == ffha_pkg::MODE_ALLOC) ? s_fit : (r_rd_off == r_key);
        o_stat.tail_fit  = s_tail_fit;
        o_stat.scan_done = !r_scan_run;
        o_stat.scan_full = s_scan_full;
        o_stat.look_ok   = (r_blk != 6'd0) && (32'(r_blk) < MAX_BLOCKS) && r_used[s_blk_id];
        o_stat.out_free  = s_out_free;
    end

    a_id_zero_unused: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_used[0])
        else $error("block id zero marked used");

    a_head_used: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_head != '0) |-> r_used[r_head])
        else $error("list head points at an unused block");

    a_new_id_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.wr_new |-> ((s_new_id != '0) && !r_used[s_new_id]))
        else $error("new block written over a used id");

    a_push_slot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.push |-> s_out_free)
        else $error("result pushed over a pending beat");

endmodule

// File: rtl/first_fit_heap_allocator_core.sv
// ----------------------------------------------------------------------------
// First-fit heap allocator core
// Keeps allocated blocks in an address-ordered linked table and serves
// allocate, free, find and address lookup requests.
//
//   Channel   Dir   Protocol     Beat contents
//   i_req     in    valid/ready  mode, req_size, req_address, req_block
//   o_rsp     out   valid/ready  result_address, result_block, status
//   apb       in    APB rd/wr    heap_base (0x0), heap_end (0x4)
//
// Allocate rounds the size (serially for a granule that is not a power of
// two), walks the list and waits for the free-id scan beside it. Free and
// find walk the list; address lookup reads the table entry of the given id.
// Reset clears the list head and used bits. A new request is accepted only
// once the previous one has handed its result to the output register.
// A pending result beat does not block the next request; a stalled output
// holds the following result until its slot frees up.
// ----------------------------------------------------------------------------
module first_fit_heap_allocator_core #(
    parameter int MAX_BLOCKS = 64,
    parameter int GRANULE    = 256
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    ffha_req_if.sink                     i_req,
    ffha_rsp_if.source                   o_rsp,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [ffha_pkg::APB_AW-1:0]  paddr,
    input  logic [31:0]                  pwdata,
    output logic [31:0]                  prdata,
    output logic                         pready
);

    ffha_pkg::t_cmd  s_cmd;
    ffha_pkg::t_stat s_stat;
    logic [31:0]     s_heap_base;
    logic [31:0]     s_heap_end;

    ffha_apb u_apb (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready),
        .o_heap_base (s_heap_base),
        .o_heap_end  (s_heap_end)
    );

    ffha_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_req.valid),
        .o_in_ready (i_req.ready),
        .i_stat     (s_stat),
        .o_cmd      (s_cmd)
    );

    ffha_dp #(
        .MAX_BLOCKS (MAX_BLOCKS),
        .GRANULE    (GRANULE)
    ) u_dp (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cmd            (s_cmd),
        .o_stat           (s_stat),
        .i_mode           (i_req.mode),
        .i_req_size       (i_req.req_size),
        .i_req_address    (i_req.req_address),
        .i_req_block      (i_req.req_block),
        .i_heap_base      (s_heap_base),
        .i_heap_end       (s_heap_end),
        .i_out_ready      (o_rsp.ready),
        .o_out_valid      (o_rsp.valid),
        .o_result_address (o_rsp.result_address),
        .o_result_block   (o_rsp.result_block),
        .o_status         (o_rsp.status)
    );

endmodule
